@@ hdl/aavr_pkg.sv @@
// ---------------------------------------------------------------------------
// aavr_pkg
// Shared widths, CORDIC constants and pipeline record types for the
// axis-angle vector rotation block.
// ---------------------------------------------------------------------------
package aavr_pkg;

    localparam int VW            = 24;
    localparam int ATAN_LEN      = 30;
    localparam int XW            = 34;
    localparam int ZW            = 33;
    localparam int DEF_STEPS     = 20;
    localparam int DEF_FRAC_BITS = 21;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(652032874);

    typedef struct packed {
        logic [2:0][VW-1:0] r;
        logic [2:0][VW-1:0] n;
    } side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
        side_t                side;
    } cordic_t;

    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/aavr_cordic_stage.sv @@
// ---------------------------------------------------------------------------
// aavr_cordic_stage
// One registered micro-rotation of the rotation-mode CORDIC.
// ---------------------------------------------------------------------------
module aavr_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  aavr_pkg::cordic_t data_in,
    output logic              valid_out,
    output aavr_pkg::cordic_t data_out
);

    localparam logic signed [aavr_pkg::ZW-1:0] ANG =
        aavr_pkg::ZW'(aavr_pkg::atan_val(IDX));

    logic                     valid_reg;
    aavr_pkg::cordic_t        data_reg;
    aavr_pkg::cordic_t        data_next;
    logic signed [aavr_pkg::XW-1:0] xs;
    logic signed [aavr_pkg::XW-1:0] ys;

    always_comb
    begin
        xs = data_in.x >>> IDX;
        ys = data_in.y >>> IDX;
        data_next = data_in;
        if (!data_in.z[aavr_pkg::ZW-1])
        begin
            data_next.x = data_in.x - ys;
            data_next.y = data_in.y + xs;
            data_next.z = data_in.z - ANG;
        end
        else
        begin
            data_next.x = data_in.x + ys;
            data_next.y = data_in.y - xs;
            data_next.z = data_in.z + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ hdl/aavr_post.sv @@
// ---------------------------------------------------------------------------
// aavr_post
// Five-stage arithmetic back end: rounds cosine and sine, forms the dot
// and cross products and combines the Rodrigues terms with saturation.
// ---------------------------------------------------------------------------
module aavr_post #(
    parameter int FRAC_BITS = aavr_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  aavr_pkg::cordic_t         data_in,
    output logic                      valid_out,
    output logic [2:0][aavr_pkg::VW-1:0] res
);

    localparam int F  = FRAC_BITS;
    localparam int VW = aavr_pkg::VW;
    localparam int XW = aavr_pkg::XW;
    localparam int SH = 30 - F;
    localparam int CW = F + 3;
    localparam int PW = 2 * VW;
    localparam int SW = PW + 2;
    localparam int DW = SW + 1 - F;
    localparam int MW = CW + 1 + DW;
    localparam int TW = MW + 1 - F;
    localparam int RW = CW + VW;
    localparam int NW = TW + VW;
    localparam int QW = CW + DW;
    localparam int FW = NW + QW + RW + 4;

    localparam logic signed [SW-1:0] HALF_S = SW'(1) << (F - 1);
    localparam logic signed [MW-1:0] HALF_M = MW'(1) << (F - 1);
    localparam logic signed [RW-1:0] HALF_R = RW'(1) << (F - 1);
    localparam logic signed [FW-1:0] HALF_F = FW'(1) << (F - 1);
    localparam logic signed [CW:0]   ONE_F  = (CW + 1)'(1) << F;
    localparam logic signed [FW-1:0] SAT_HI = FW'(8388607);
    localparam logic signed [FW-1:0] SAT_LO = -FW'(8388608);

    logic signed [XW-1:0] xn;
    logic signed [XW-1:0] yn;
    logic signed [CW-1:0] cf_next;
    logic signed [CW-1:0] sf_next;

    assign xn = data_in.flip ? -data_in.x : data_in.x;
    assign yn = data_in.flip ? -data_in.y : data_in.y;

    generate
        if (SH == 0)
        begin : g_noround
            assign cf_next = CW'(xn);
            assign sf_next = CW'(yn);
        end
        else
        begin : g_round
            localparam logic signed [XW-1:0] HALF_X = XW'(1) << (SH - 1);
            assign cf_next = CW'((xn + HALF_X) >>> SH);
            assign sf_next = CW'((yn + HALF_X) >>> SH);
        end
    endgenerate

    // stage 1
    logic                 v1_reg;
    logic signed [CW-1:0] cf1_reg;
    logic signed [CW-1:0] sf1_reg;
    aavr_pkg::side_t      s1_reg;
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] pc_reg [6];
    logic signed [PW-1:0] pd_next [3];
    logic signed [PW-1:0] pc_next [6];

    // stage 2
    logic                 v2_reg;
    logic signed [CW-1:0] cf2_reg;
    logic signed [CW-1:0] sf2_reg;
    aavr_pkg::side_t      s2_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] w2_reg [3];
    logic signed [DW-1:0] d_next;
    logic signed [DW-1:0] w_next [3];
    logic signed [SW-1:0] sum_d;
    logic signed [SW-1:0] sum_w [3];

    // stage 3
    logic                 v3_reg;
    logic signed [CW-1:0] sf3_reg;
    logic [2:0][VW-1:0]   n3_reg;
    logic signed [DW-1:0] w3_reg [3];
    logic signed [MW-1:0] m_reg;
    logic signed [RW-1:0] cr_reg [3];
    logic signed [MW-1:0] m_next;
    logic signed [RW-1:0] cr_next [3];

    // stage 4
    logic                 v4_reg;
    logic signed [NW-1:0] tn_reg [3];
    logic signed [QW-1:0] sw_reg [3];
    logic signed [RW-1:0] crr_reg [3];
    logic signed [TW-1:0] t_val;
    logic signed [NW-1:0] tn_next [3];
    logic signed [QW-1:0] sw_next [3];
    logic signed [RW-1:0] crr_next [3];

    // stage 5
    logic                 v5_reg;
    logic [2:0][VW-1:0]   res_reg;
    logic [2:0][VW-1:0]   res_next;
    logic signed [FW-1:0] acc [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pd_next[i] = $signed(data_in.side.n[i]) * $signed(data_in.side.r[i]);
        pc_next[0] = $signed(data_in.side.n[1]) * $signed(data_in.side.r[2]);
        pc_next[1] = $signed(data_in.side.n[2]) * $signed(data_in.side.r[1]);
        pc_next[2] = $signed(data_in.side.n[2]) * $signed(data_in.side.r[0]);
        pc_next[3] = $signed(data_in.side.n[0]) * $signed(data_in.side.r[2]);
        pc_next[4] = $signed(data_in.side.n[0]) * $signed(data_in.side.r[1]);
        pc_next[5] = $signed(data_in.side.n[1]) * $signed(data_in.side.r[0]);
    end

    always_comb
    begin
        sum_d = SW'(pd_reg[0]) + SW'(pd_reg[1]) + SW'(pd_reg[2]);
        d_next = DW'((sum_d + HALF_S) >>> F);
        for (int i = 0; i < 3; i++)
        begin
            sum_w[i]  = SW'(pc_reg[2*i]) - SW'(pc_reg[2*i+1]);
            w_next[i] = DW'((sum_w[i] + HALF_S) >>> F);
        end
    end

    always_comb
    begin
        m_next = (ONE_F - (CW + 1)'(cf2_reg)) * d_reg;
        for (int i = 0; i < 3; i++)
            cr_next[i] = cf2_reg * $signed(s2_reg.r[i]);
    end

    always_comb
    begin
        t_val = TW'((m_reg + HALF_M) >>> F);
        for (int i = 0; i < 3; i++)
        begin
            tn_next[i]  = t_val * $signed(n3_reg[i]);
            sw_next[i]  = sf3_reg * w3_reg[i];
            crr_next[i] = (cr_reg[i] + HALF_R) >>> F;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ((FW'(tn_reg[i]) + HALF_F) >>> F) + FW'(crr_reg[i])
                   - ((FW'(sw_reg[i]) + HALF_F) >>> F);
            if (acc[i] > SAT_HI)
                res_next[i] = SAT_HI[VW-1:0];
            else if (acc[i] < SAT_LO)
                res_next[i] = SAT_LO[VW-1:0];
            else
                res_next[i] = acc[i][VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cf1_reg <= cf_next;
            sf1_reg <= sf_next;
            s1_reg  <= data_in.side;
            pd_reg  <= pd_next;
            pc_reg  <= pc_next;
            cf2_reg <= cf1_reg;
            sf2_reg <= sf1_reg;
            s2_reg  <= s1_reg;
            d_reg   <= d_next;
            w2_reg  <= w_next;
            sf3_reg <= sf2_reg;
            n3_reg  <= s2_reg.n;
            w3_reg  <= w2_reg;
            m_reg   <= m_next;
            cr_reg  <= cr_next;
            tn_reg  <= tn_next;
            sw_reg  <= sw_next;
            crr_reg <= crr_next;
            res_reg <= res_next;
        end
    end

    assign valid_out = v5_reg;
    assign res       = res_reg;

endmodule

@@ hdl/axis_angle_vector_rotation.sv @@
// ---------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rotates a Q2.21 vector about a given axis by a binary angle using the
// Rodrigues formula, with cosine and sine from a pipelined CORDIC.
// ---------------------------------------------------------------------------
// Fully pipelined: one item is accepted per clock unless a valid result is
// stalled on the output. Each result passes through one input stage, one
// register per CORDIC micro-rotation and five arithmetic stages. A stall on
// the output while a result is valid holds the whole pipeline; nothing is
// dropped or repeated. The axis is used as given, without normalization,
// and each output component saturates.
module axis_angle_vector_rotation #(
    parameter int CORDIC_STEPS = aavr_pkg::DEF_STEPS,
    parameter int FRAC_BITS    = aavr_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] vec_x,
    input  logic [23:0] vec_y,
    input  logic [23:0] vec_z,
    input  logic [23:0] axis_x,
    input  logic [23:0] axis_y,
    input  logic [23:0] axis_z,
    input  logic [23:0] angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] out_x,
    output logic [23:0] out_y,
    output logic [23:0] out_z
);

    localparam int NSTEPS = (CORDIC_STEPS < aavr_pkg::ATAN_LEN) ?
                            CORDIC_STEPS : aavr_pkg::ATAN_LEN;

    logic                    en;
    logic                    v0_reg;
    aavr_pkg::cordic_t       d0_reg;
    aavr_pkg::cordic_t       d0_next;
    logic                    vc [NSTEPS+1];
    aavr_pkg::cordic_t       dc [NSTEPS+1];
    logic                    post_valid;
    logic [2:0][aavr_pkg::VW-1:0] res;

    assign en       = !(post_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        d0_next.x      = aavr_pkg::CORDIC_GAIN_Q30;
        d0_next.y      = '0;
        d0_next.flip   = angle[23] ^ angle[22];
        d0_next.z      = aavr_pkg::ZW'($signed({angle[22], angle[22:0], 8'b0}));
        d0_next.side.r = {vec_z, vec_y, vec_x};
        d0_next.side.n = {axis_z, axis_y, axis_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d0_reg <= d0_next;
    end

    assign vc[0] = v0_reg;
    assign dc[0] = d0_reg;

    generate
        for (genvar k = 0; k < NSTEPS; k++)
        begin : g_step
            aavr_cordic_stage #(
                .IDX(k)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .valid_in (vc[k]),
                .data_in  (dc[k]),
                .valid_out(vc[k+1]),
                .data_out (dc[k+1])
            );
        end
    endgenerate

    aavr_post #(
        .FRAC_BITS(FRAC_BITS)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (vc[NSTEPS]),
        .data_in  (dc[NSTEPS]),
        .valid_out(post_valid),
        .res      (res)
    );

    assign out_valid = post_valid;
    assign out_x     = res[0];
    assign out_y     = res[1];
    assign out_z     = res[2];

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for axis_angle_vector_rotation: drives vector, axis
// and angle items with random idling on both sides and compares each
// rotated vector with a bit-exact fixed-point prediction.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = aavr_pkg::DEF_STEPS;
    localparam int FB    = aavr_pkg::DEF_FRAC_BITS;
    localparam int LATENCY = 1 + STEPS + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } vec3_t;

    class rotation_scoreboard;
        vec3_t pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function longint fshr(longint v, int k);
            return v >>> k;
        endfunction

        static function longint rshr(longint v, int k);
            if (k == 0)
                return v;
            return (v + (longint'(1) << (k - 1))) >>> k;
        endfunction

        static function logic [23:0] clamp24(longint v);
            if (v > 8388607)
                v = 8388607;
            if (v < -8388608)
                v = -8388608;
            return v[23:0];
        endfunction

        static function void sincos(logic [23:0] ang, output longint c,
                                    output longint s);
            logic [31:0] ph;
            logic        flip;
            longint      x, y, z, nx;
            ph = {ang, 8'd0};
            flip = ph[31] != ph[30];
            x = 652032874;
            y = 0;
            if (flip)
                ph[31] = ~ph[31];
            z = longint'($signed(ph));
            for (int i = 0; i < STEPS && i < aavr_pkg::ATAN_LEN; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - fshr(y, i);
                    y = y + fshr(x, i);
                    z -= longint'(aavr_pkg::atan_val(i));
                end
                else
                begin
                    nx = x + fshr(y, i);
                    y = y - fshr(x, i);
                    z += longint'(aavr_pkg::atan_val(i));
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        function void note_item(logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                                logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                                logic [23:0] ang);
            longint r[3], n[3], w[3], o[3], cq, sq, cf, sf, d, t;
            vec3_t  e;
            r[0] = longint'($signed(vx));
            r[1] = longint'($signed(vy));
            r[2] = longint'($signed(vz));
            n[0] = longint'($signed(ax));
            n[1] = longint'($signed(ay));
            n[2] = longint'($signed(az));
            sincos(ang, cq, sq);
            cf = rshr(cq, 30 - FB);
            sf = rshr(sq, 30 - FB);
            d = rshr(n[0] * r[0] + n[1] * r[1] + n[2] * r[2], FB);
            w[0] = rshr(n[1] * r[2] - n[2] * r[1], FB);
            w[1] = rshr(n[2] * r[0] - n[0] * r[2], FB);
            w[2] = rshr(n[0] * r[1] - n[1] * r[0], FB);
            t = rshr(((longint'(1) << FB) - cf) * d, FB);
            for (int i = 0; i < 3; i++)
                o[i] = rshr(t * n[i], FB) + rshr(cf * r[i], FB) - rshr(sf * w[i], FB);
            e.x = clamp24(o[0]);
            e.y = clamp24(o[1]);
            e.z = clamp24(o[2]);
            pending.push_back(e);
        endfunction

        function void check_result(logic [23:0] x, logic [23:0] y, logic [23:0] z);
            vec3_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h %h %h", x, y, z);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x)
            begin
                $error("out_x expected %h actual %h", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("out_y expected %h actual %h", e.y, y);
                errors++;
            end
            if (z !== e.z)
            begin
                $error("out_z expected %h actual %h", e.z, z);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [23:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic [23:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] out_x, out_y, out_z;

    rotation_scoreboard sb = new();
    longint cycles = 0;
    bit     calm = 1'b0;
    bit     sink_on = 1'b0;

    always #10 clk = ~clk;

    axis_angle_vector_rotation uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // check at the edge, then pick the next stall value
    int stall_left = 0, run_left = 0;
    always @(posedge clk)
    begin
        if (sink_on)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_x, out_y, out_z);
            if (calm)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
            begin
                run_left = $urandom_range(1, 30);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [23:0] pick_comp();
        unique case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h200000;
            3: return 24'hE00000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_axis(int k);
        // mostly a rough unit axis: one large component, the others small
        logic [23:0] v;
        if ($urandom_range(0, 9) == 0)
            return pick_comp();
        v = 24'($signed(24'($urandom_range(0, 600000))) - 300000);
        if (k == 0)
            v = $urandom_range(0, 1) ? 24'h200000 - v : 24'hE00000 + v;
        return v;
    endfunction

    task automatic send_item(logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                             logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                             logic [23:0] ang);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        axis_x <= ax;
        axis_y <= ay;
        axis_z <= az;
        angle <= ang;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(vx, vy, vz, ax, ay, az, ang);
    endtask

    logic [23:0] angles[8] = '{24'h000000, 24'h800000, 24'h7FFFFF, 24'h400000,
                               24'hC00000, 24'h3FFFFF, 24'h400001, 24'h200000};

    initial
    begin
        int lead, wait_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        sink_on = 1'b1;
        @(posedge clk);
        foreach (angles[i])
            send_item(24'h200000, 24'h100000, 24'hF00000,
                      24'h000000, 24'h000000, 24'h200000, angles[i]);
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h155555);
        send_item(24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send_item(24'h800000, 24'h7FFFFF, 24'h000000,
                  24'h7FFFFF, 24'h800000, 24'h000000, 24'h400000);
        send_item(24'hFFFFFF, 24'h000001, 24'h555555,
                  24'hAAAAAA, 24'h000000, 24'h200000, 24'hFFFFFF);
        send_item(24'h000000, 24'h000000, 24'h000000,
                  24'h200000, 24'h000000, 24'h000000, 24'h123456);
        send_item(24'h7FFFFF, 24'h000000, 24'h000000,
                  24'h000000, 24'h200000, 24'h000000, 24'h400000);
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 1200)
                calm = 1'b1;
            lead = $urandom_range(0, 2);
            send_item(pick_comp(), pick_comp(), pick_comp(),
                      pick_axis(lead == 0 ? 0 : 1), pick_axis(lead == 1 ? 0 : 1),
                      pick_axis(lead == 2 ? 0 : 1), 24'($urandom));
        end
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/aavr_pkg.sv
hdl/aavr_cordic_stage.sv
hdl/aavr_post.sv
hdl/axis_angle_vector_rotation.sv
tb/sv/tb.sv
